FILE: hw/rtl/gmo_pkg.sv
// Shared types, register indexes and constants for the grayscale octagon
// erosion/dilation core. No dependencies.
package gmo_pkg;

    localparam int PIX_W  = 8;
    localparam int CFG_W  = 11;
    localparam int CFG_AW = 2;
    localparam int HGT_W  = 11;
    localparam int TAPS   = 5;

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        logic cmd;
        pix_t pixel;
    } pix_beat_t;

    typedef struct packed {
        pix_t result_pixel;
        logic last_of_frame;
    } res_beat_t;

    localparam logic [CFG_AW-1:0] REG_MODE   = 2'd0;
    localparam logic [CFG_AW-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_AW-1:0] REG_HEIGHT = 2'd2;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd512;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd512;

    // bit (slot*5 + depth); the four corners of the 5x5 square are off
    localparam logic [TAPS*TAPS-1:0] TAP_USED = 25'b0_1110_1111_1111_1111_1110_1110;

    function automatic pix_t pick(input logic dilate, input pix_t a, input pix_t b);
        pix_t r;
        if (dilate)
        begin
            r = (a > b) ? a : b;
        end
        else
        begin
            r = (a < b) ? a : b;
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/gmo_ram.sv
// Generic simple dual-port RAM, one write and one read port, registered read.
// No dependencies.
module gmo_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/grayscale_morphology_octagon_core.sv
// Top level of the streaming 5x5 octagon erosion/dilation core.
// Depends on gmo_pkg and gmo_ram (column-indexed store of the last four rows).
//
//   channel  signals                        beat
//   pix      pix_valid/pix_ready/pix_data   cmd, pixel (raster order)
//   res      res_valid/res_ready/res_data   result_pixel, last_of_frame
//   cfg      cfg_en/cfg_addr/cfg_data       mode, image_width, image_height
//
// One pix beat per cycle sustained while res is not stalled; the line store
// takes one read and one write per cycle. res_valid rises once the beat that
// completes a window has passed s1, s2 and s3. Reset clears control state
// only; the line store needs no clear.
// pix_ready drops only when a result waits on res and all stages behind it
// are full.
module grayscale_morphology_octagon_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pix_valid,
    output logic                          pix_ready,
    input  gmo_pkg::pix_beat_t            pix_data,
    output logic                          res_valid,
    input  logic                          res_ready,
    output gmo_pkg::res_beat_t            res_data,
    input  logic                          cfg_en,
    input  logic [gmo_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [gmo_pkg::CFG_W-1:0]     cfg_data
);

    import gmo_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int CNT_W = WID_W + 2;
    localparam int WORD_W = 4 * PIX_W;

    logic               mode_reg;
    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;

    logic [COL_W-1:0]   in_col_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [COL_W-1:0]   out_col_reg;
    logic [HGT_W-1:0]   out_row_reg;
    logic [COL_W-1:0]   in_col_next;
    logic [CNT_W-1:0]   cnt_next;
    logic [COL_W-1:0]   out_col_next;
    logic [HGT_W-1:0]   out_row_next;

    logic [WID_W-1:0]   eff_w;
    logic [HGT_W-1:0]   eff_h;
    logic [CNT_W-1:0]   thresh;
    logic               emit_now;
    logic               last_now;
    logic [TAPS-1:0]    rv;
    logic [TAPS-1:0]    cv;

    logic               accept;
    logic               res_free;
    logic               s3_free;
    logic               s2_free;
    logic               s1_free;
    logic               s1_go;
    logic               s2_go;
    logic               s3_go;

    logic               s1_valid_reg;
    logic [COL_W-1:0]   s1_col_reg;
    pix_t               s1_pix_reg;
    logic               s1_emit_reg;
    logic               s1_last_reg;
    logic [TAPS-1:0]    s1_rv_reg;
    logic [TAPS-1:0]    s1_cv_reg;
    logic               s1_fwd_reg;
    logic [WORD_W-1:0]  s1_fwd_word_reg;

    logic [WORD_W-1:0]  ram_rd;
    logic [WORD_W-1:0]  rd_word;
    logic [WORD_W-1:0]  wr_word;
    pix_t               vec [TAPS];

    logic               s2_valid_reg;
    logic               s2_emit_reg;
    logic               s2_last_reg;
    logic [TAPS*TAPS-1:0] s2_mask_reg;
    pix_t               win_reg [TAPS][TAPS];

    logic               s3_valid_reg;
    logic               s3_last_reg;
    pix_t               s3_row_reg [TAPS];
    pix_t               row_red [TAPS];

    logic               res_valid_reg;
    res_beat_t          res_data_reg;
    pix_t               neutral;
    pix_t               fin;

    // effective frame size
    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_w = WID_W'(1);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            eff_w = WID_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WID_W'(width_reg);
        end
        eff_h = (height_reg == '0) ? HGT_W'(1) : height_reg;
    end

    assign thresh   = CNT_W'({eff_w, 1'b0}) + CNT_W'(2);
    assign emit_now = (cnt_reg == thresh);
    assign last_now = emit_now && (out_row_reg == eff_h - HGT_W'(1))
                      && (WID_W'(out_col_reg) == eff_w - WID_W'(1));

    // kernel rows and columns inside the frame for the current centre
    always_comb
    begin
        rv[0] = (out_row_reg >= HGT_W'(2));
        rv[1] = (out_row_reg >= HGT_W'(1));
        rv[2] = 1'b1;
        rv[3] = ((HGT_W + 1)'(out_row_reg) + (HGT_W + 1)'(1)) < (HGT_W + 1)'(eff_h);
        rv[4] = ((HGT_W + 1)'(out_row_reg) + (HGT_W + 1)'(2)) < (HGT_W + 1)'(eff_h);
        cv[0] = (out_col_reg >= COL_W'(2));
        cv[1] = (out_col_reg >= COL_W'(1));
        cv[2] = 1'b1;
        cv[3] = ((WID_W + 1)'(out_col_reg) + (WID_W + 1)'(1)) < (WID_W + 1)'(eff_w);
        cv[4] = ((WID_W + 1)'(out_col_reg) + (WID_W + 1)'(2)) < (WID_W + 1)'(eff_w);
    end

    assign res_free  = !res_valid_reg || res_ready;
    assign s3_free   = !s3_valid_reg || res_free;
    assign s2_free   = !s2_valid_reg || s3_free;
    assign s1_free   = !s1_valid_reg || s2_free;
    assign pix_ready = s1_free;
    assign accept    = pix_valid && s1_free;
    assign s1_go     = s1_valid_reg && s2_free;
    assign s2_go     = s2_valid_reg && s3_free;
    assign s3_go     = s3_valid_reg && res_free;

    always_comb
    begin
        in_col_next  = in_col_reg;
        cnt_next     = cnt_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (last_now)
        begin
            in_col_next  = '0;
            cnt_next     = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else
        begin
            if (WID_W'(in_col_reg) == eff_w - WID_W'(1))
            begin
                in_col_next = '0;
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end
            if (emit_now)
            begin
                if (WID_W'(out_col_reg) == eff_w - WID_W'(1))
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + HGT_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
            else
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 1'b0;
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
            in_col_reg  <= '0;
            cnt_reg     <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (cfg_en)
        begin
            case (cfg_addr)
                REG_MODE:
                begin
                    mode_reg <= cfg_data[0];
                end
                REG_WIDTH:
                begin
                    width_reg   <= cfg_data;
                    in_col_reg  <= '0;
                    cnt_reg     <= '0;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                end
                REG_HEIGHT:
                begin
                    height_reg  <= cfg_data;
                    in_col_reg  <= '0;
                    cnt_reg     <= '0;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                end
                default:
                begin
                    mode_reg <= mode_reg;
                end
            endcase
        end
        else if (accept)
        begin
            in_col_reg  <= in_col_next;
            cnt_reg     <= cnt_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // line store: entry per column, four rows deep, newest row in the low byte
    assign rd_word = s1_fwd_reg ? s1_fwd_word_reg : ram_rd;
    assign wr_word = {rd_word[3*PIX_W-1:0], s1_pix_reg};

    gmo_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (s1_go),
        .wr_addr (s1_col_reg),
        .wr_data (wr_word),
        .rd_en   (accept),
        .rd_addr (in_col_reg),
        .rd_data (ram_rd)
    );

    always_comb
    begin
        vec[0] = s1_pix_reg;
        for (int m = 1; m < TAPS; m++)
        begin
            vec[m] = rd_word[(m-1)*PIX_W +: PIX_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= accept;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_valid_reg && s2_emit_reg;
            end
            if (res_free)
            begin
                res_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg      <= in_col_reg;
            s1_pix_reg      <= pix_data.cmd ? '0 : pix_data.pixel;
            s1_emit_reg     <= emit_now;
            s1_last_reg     <= last_now;
            s1_rv_reg       <= rv;
            s1_cv_reg       <= cv;
            s1_fwd_reg      <= s1_valid_reg && (s1_col_reg == in_col_reg);
            s1_fwd_word_reg <= wr_word;
        end
        if (s1_go)
        begin
            s2_emit_reg <= s1_emit_reg;
            s2_last_reg <= s1_last_reg;
            for (int s = 0; s < TAPS; s++)
            begin
                for (int m = 0; m < TAPS; m++)
                begin
                    s2_mask_reg[s*TAPS+m] <= TAP_USED[s*TAPS+m] && s1_rv_reg[TAPS-1-m]
                                             && s1_cv_reg[TAPS-1-s];
                end
            end
            for (int m = 0; m < TAPS; m++)
            begin
                win_reg[0][m] <= vec[m];
            end
            for (int s = 1; s < TAPS; s++)
            begin
                for (int m = 0; m < TAPS; m++)
                begin
                    win_reg[s][m] <= win_reg[s-1][m];
                end
            end
        end
        if (s2_go && s2_emit_reg)
        begin
            s3_last_reg <= s2_last_reg;
            for (int m = 0; m < TAPS; m++)
            begin
                s3_row_reg[m] <= row_red[m];
            end
        end
        if (s3_go)
        begin
            res_data_reg.result_pixel  <= fin;
            res_data_reg.last_of_frame <= s3_last_reg;
        end
    end

    assign neutral = mode_reg ? '0 : '1;

    always_comb
    begin
        for (int m = 0; m < TAPS; m++)
        begin
            row_red[m] = neutral;
            for (int s = 0; s < TAPS; s++)
            begin
                row_red[m] = pick(mode_reg, row_red[m],
                                  s2_mask_reg[s*TAPS+m] ? win_reg[s][m] : neutral);
            end
        end
    end

    always_comb
    begin
        fin = neutral;
        for (int m = 0; m < TAPS; m++)
        begin
            fin = pick(mode_reg, fin, s3_row_reg[m]);
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

FILE: tb/sv/tb.sv
// Self-checking bench for grayscale_morphology_octagon_core: 5x5 octagon erosion and dilation
// over streamed frames, each result beat compared against an in-bench window predictor.
// Depends on gmo_pkg and the core RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gmo_pkg::*;

    localparam int MAX_WIDTH     = 1024;
    localparam int HISTORY_DEPTH = 4 * MAX_WIDTH + 8;
    localparam int LATENCY_PAD   = 16;
    localparam int STALL_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_ITEMS  = 800;

    localparam logic CMD_PIXEL   = 1'b0;
    localparam logic CMD_PAD     = 1'b1;
    localparam logic MODE_ERODE  = 1'b0;
    localparam logic MODE_DILATE = 1'b1;

    localparam logic [2:0] SET_MODE   = 3'b001 << REG_MODE;
    localparam logic [2:0] SET_WIDTH  = 3'b001 << REG_WIDTH;
    localparam logic [2:0] SET_HEIGHT = 3'b001 << REG_HEIGHT;
    localparam logic [2:0] SET_ALL    = SET_MODE | SET_WIDTH | SET_HEIGHT;

    class octagon_scoreboard;
        pix_t             history [HISTORY_DEPTH];
        logic             dilate;
        logic [CFG_W-1:0] width_reg;
        logic [CFG_W-1:0] height_reg;
        int               in_col;
        int               in_row;
        int               out_col;
        int               out_row;
        res_beat_t        awaited [$];
        int               errors;

        function new();
            foreach (history[i]) history[i] = '0;
            dilate     = MODE_ERODE;
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            errors     = 0;
            restart();
        endfunction

        function void restart();
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
        endfunction

        function int eff_width();
            if (width_reg == 0) return 1;
            if (width_reg > MAX_WIDTH) return MAX_WIDTH;
            return int'(width_reg);
        endfunction

        function int eff_height();
            return (height_reg == 0) ? 1 : int'(height_reg);
        endfunction

        function void set_register(logic [CFG_AW-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_MODE:
                begin
                    dilate = val[0];
                end
                REG_WIDTH:
                begin
                    width_reg = val;
                    restart();
                end
                REG_HEIGHT:
                begin
                    height_reg = val;
                    restart();
                end
                default:
                begin
                end
            endcase
        endfunction

        function pix_t octagon_extreme(int w, int h);
            pix_t best;
            pix_t v;
            int   rr;
            int   cc;
            best = dilate ? 8'h00 : 8'hFF;
            for (int di = -2; di <= 2; di++)
            begin
                for (int dj = -2; dj <= 2; dj++)
                begin
                    rr = out_row + di;
                    cc = out_col + dj;
                    // skip the four corners and points outside the image
                    if (di * di + dj * dj < 8 && rr >= 0 && cc >= 0 && rr < h && cc < w)
                    begin
                        v = history[(rr * w + cc) % HISTORY_DEPTH];
                        if (dilate ? (v > best) : (v < best)) best = v;
                    end
                end
            end
            return best;
        endfunction

        function void accept_pixel(pix_beat_t beat);
            int        w;
            int        h;
            int        k;
            res_beat_t r;
            w = eff_width();
            h = eff_height();
            k = in_row * w + in_col;
            if (in_row < h) history[k % HISTORY_DEPTH] = (beat.cmd == CMD_PAD) ? 8'h00 : beat.pixel;
            if (k >= 2 * w + 2)
            begin
                r.result_pixel  = octagon_extreme(w, h);
                r.last_of_frame = (out_row == h - 1) && (out_col == w - 1);
                awaited.push_back(r);
                if (r.last_of_frame)
                begin
                    restart();
                    return;
                end
                out_col++;
                if (out_col >= w)
                begin
                    out_col = 0;
                    out_row++;
                end
            end
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
            end
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH at %0t: %s", $time, msg);
        endtask

        task check_result(res_beat_t got);
            res_beat_t want;
            if (awaited.size() == 0)
            begin
                report($sformatf("unexpected result beat pixel %02h last %0b",
                                 got.result_pixel, got.last_of_frame));
                return;
            end
            want = awaited.pop_front();
            if (got.result_pixel !== want.result_pixel)
                report($sformatf("result_pixel got %02h want %02h",
                                 got.result_pixel, want.result_pixel));
            if (got.last_of_frame !== want.last_of_frame)
                report($sformatf("last_of_frame got %0b want %0b",
                                 got.last_of_frame, want.last_of_frame));
        endtask
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              pix_valid;
    logic              pix_ready;
    pix_beat_t         pix_data;
    logic              res_valid;
    logic              res_ready;
    res_beat_t         res_data;
    logic              cfg_en;
    logic [CFG_AW-1:0] cfg_addr;
    logic [CFG_W-1:0]  cfg_data;

    bit                no_gaps = 1'b0;
    bit                hold_req = 1'b0;
    int                items_sent = 0;
    octagon_scoreboard morph_sb;
    pix_beat_t         erode_beats [14];
    pix_beat_t         dilate_beats [11];

    always #4 clk = ~clk;

    grayscale_morphology_octagon_core #(
        .MAX_WIDTH(MAX_WIDTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .pix_valid(pix_valid),
        .pix_ready(pix_ready),
        .pix_data (pix_data),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res_data (res_data),
        .cfg_en   (cfg_en),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    task automatic send_beat(input pix_beat_t beat);
        while (!no_gaps && $urandom_range(0, 99) < 26)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= beat;
        @(posedge clk);
        while (!pix_ready) @(posedge clk);
        morph_sb.accept_pixel(beat);
        items_sent++;
    endtask

    task automatic settle();
        pix_valid <= 1'b0;
        while (morph_sb.awaited.size() != 0) @(posedge clk);
        repeat (LATENCY_PAD) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_en   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        morph_sb.set_register(idx, val);
    endtask

    task automatic configure(input logic [2:0] pick, input logic mode_v,
                             input logic [CFG_W-1:0] width_v, input logic [CFG_W-1:0] height_v);
        if (pick[REG_MODE]) write_reg(REG_MODE, CFG_W'(mode_v));
        if (pick[REG_WIDTH]) write_reg(REG_WIDTH, width_v);
        if (pick[REG_HEIGHT]) write_reg(REG_HEIGHT, height_v);
        cfg_en <= 1'b0;
    endtask

    task automatic stream_frame(input int w, input int h, input int count);
        pix_beat_t beat;
        for (int i = 0; i < count; i++)
        begin
            if (i < w * h)
                beat.cmd = ($urandom_range(0, 99) < 7) ? CMD_PAD : CMD_PIXEL;
            else
                beat.cmd = ($urandom_range(0, 99) < 15) ? CMD_PIXEL : CMD_PAD;
            if ($urandom_range(0, 9) == 0)
                beat.pixel = {PIX_W{1'($urandom_range(0, 1))}};
            else
                beat.pixel = pix_t'($urandom_range(0, 255));
            send_beat(beat);
        end
    endtask

    function automatic logic [CFG_W-1:0] random_size(input int typical);
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) return '0;
        if (roll == 1) return CFG_W'($urandom_range(typical + 1, 3 * typical));
        return CFG_W'($urandom_range(1, typical));
    endfunction

    task automatic random_phase();
        int total;
        int count;
        int frames;
        settle();
        configure(3'($urandom_range(1, 7)), 1'($urandom_range(0, 1)),
                  random_size(12), random_size(8));
        frames = $urandom_range(1, 3);
        for (int f = 0; f < frames; f++)
        begin
            total = morph_sb.eff_width() * morph_sb.eff_height() + 2 * morph_sb.eff_width() + 2;
            count = total;
            // drop the tail of the last frame now and then
            if (f == frames - 1 && $urandom_range(0, 4) == 0) count = $urandom_range(1, total - 1);
            stream_frame(morph_sb.eff_width(), morph_sb.eff_height(), count);
        end
    endtask

    initial
    begin
        int hold_left;
        hold_left = 0;
        res_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (res_valid && res_ready) morph_sb.check_result(res_data);
            if (hold_left > 0)
            begin
                hold_left--;
                res_ready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                res_ready <= 1'b0;
            end
            else
            begin
                res_ready <= no_gaps || ($urandom_range(0, 99) >= 26);
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (rst_n !== 1'b1 || (pix_valid && pix_ready) || (res_valid && res_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int random_goal;
        morph_sb = new();
        rst_n     <= 1'b0;
        pix_valid <= 1'b0;
        pix_data  <= '0;
        cfg_en    <= 1'b0;
        cfg_addr  <= REG_MODE;
        cfg_data  <= '0;
        erode_beats = '{
            {CMD_PIXEL, 8'hFF}, {CMD_PIXEL, 8'h00}, {CMD_PIXEL, 8'hAA}, {CMD_PIXEL, 8'h55},
            {CMD_PAD, 8'h3C}, {CMD_PIXEL, 8'hFF}, {CMD_PIXEL, 8'h7B}, {CMD_PAD, 8'hFF},
            {CMD_PAD, 8'h00}, {CMD_PAD, 8'h80}, {CMD_PAD, 8'h01}, {CMD_PAD, 8'hFF},
            {CMD_PAD, 8'h00}, {CMD_PAD, 8'h00}
        };
        dilate_beats = '{
            {CMD_PIXEL, 8'h00}, {CMD_PIXEL, 8'h80}, {CMD_PIXEL, 8'h7F}, {CMD_PIXEL, 8'h42},
            {CMD_PAD, 8'hFF}, {CMD_PAD, 8'h00}, {CMD_PAD, 8'h00}, {CMD_PAD, 8'h00},
            {CMD_PAD, 8'h00}, {CMD_PAD, 8'h00}, {CMD_PAD, 8'h00}
        };
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        configure(SET_ALL, MODE_ERODE, 11'd3, 11'd2);
        foreach (erode_beats[i]) send_beat(erode_beats[i]);
        settle();
        configure(SET_MODE | SET_HEIGHT, MODE_DILATE, 11'd3, 11'd1);
        foreach (dilate_beats[i]) send_beat(dilate_beats[i]);
        settle();
        configure(SET_WIDTH | SET_HEIGHT, MODE_DILATE, 11'd0, 11'd0);
        stream_frame(1, 1, 5);
        stream_frame(1, 1, 5);

        random_goal = items_sent + RANDOM_ITEMS;
        while (items_sent < random_goal) random_phase();

        settle();
        configure(SET_ALL, MODE_DILATE, 11'd1, 11'd1024);
        no_gaps  = 1'b1;
        hold_req = 1'b1;
        stream_frame(1, 1024, 1024 + 4);
        no_gaps = 1'b0;
        settle();

        if (morph_sb.awaited.size() != 0) morph_sb.report("results still awaited at end of run");
        if (morph_sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

FILE: sim.f
hw/rtl/gmo_pkg.sv
hw/rtl/gmo_ram.sv
hw/rtl/grayscale_morphology_octagon_core.sv
tb/sv/tb.sv
